@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// when the condition holds, the consequence holds in the next cycle
`define ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/stog_pkg.sv @@
// shared types and constants of the spiral tile order generator
package stog_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_TILE_SIZE   = 2'd2;

	// configuration reset values
	localparam logic [6:0] GRID_WIDTH_RST  = 7'd16;
	localparam logic [6:0] GRID_HEIGHT_RST = 7'd16;
	localparam logic [8:0] TILE_SIZE_RST   = 9'd32;

	// default upper clamp of the grid dimensions
	localparam int MAX_GRID_DEF = 64;

	// ring growth and the last ring length that may still grow
	localparam logic [7:0] RING_STEP  = 8'd2;
	localparam logic [7:0] RING_LIMIT = 8'd252;

	// legs of one ring
	localparam logic [2:0] LEG_UP0   = 3'd0;
	localparam logic [2:0] LEG_RIGHT = 3'd1;
	localparam logic [2:0] LEG_DOWN  = 3'd2;
	localparam logic [2:0] LEG_LEFT  = 3'd3;
	localparam logic [2:0] LEG_UP    = 3'd4;

	// sequence phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WALK = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	// commands from controller to datapath
	typedef struct packed {
		logic start_center;
		logic step;
		logic mult;
		logic set_done;
		logic load_out;
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic phase_idle;
		logic phase_walk;
		logic hit;
		logic seq_end;
	} dp_status_t;

endpackage

@@ hw/rtl/stog_dp.sv @@
// datapath: config registers, spiral walk state, origin multiply, output payload
module stog_dp
	import stog_pkg::*;
#(
	parameter int MAX_GRID = MAX_GRID_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_wdata,
	input  ctrl_cmd_t   cmd,
	output dp_status_t  status,
	output logic [11:0] tile_index,
	output logic [13:0] origin_x,
	output logic [13:0] origin_y,
	output logic        done_res
);

	// position range: center up to MAX_GRID/2 plus a ring offset up to 127
	localparam int POS_W  = $clog2(MAX_GRID / 2 + 128) + 1;
	localparam int PROD_W = POS_W - 1 + 9;

	logic [6:0] grid_width_q, grid_height_q;
	logic [8:0] tile_size_q;

	logic signed [POS_W-1:0] col_q, row_q;
	logic [7:0]  ring_q, steps_q;
	logic [2:0]  leg_q;
	logic        placed_q;
	logic [11:0] idx_q, cur_idx_q;
	phase_t      phase_q;
	logic        done_q;
	logic [PROD_W-1:0] prod_x_q, prod_y_q;

	logic [6:0] eff_w, eff_h;
	logic [8:0] eff_ts;
	logic signed [POS_W-1:0] col_n, row_n, ctr_col, ctr_row;
	logic [7:0] ring_n, steps_n;
	logic [2:0] leg_n;
	logic       placed_n, step_hit, step_end;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
			tile_size_q   <= TILE_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_wdata[6:0];
				CFG_GRID_HEIGHT: grid_height_q <= cfg_wdata[6:0];
				CFG_TILE_SIZE:   tile_size_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// clamp the registers to their usable ranges
	always_comb begin
		if (grid_width_q == 7'd0) eff_w = 7'd1;
		else if (32'(grid_width_q) > MAX_GRID) eff_w = 7'(MAX_GRID);
		else eff_w = grid_width_q;
		if (grid_height_q == 7'd0) eff_h = 7'd1;
		else if (32'(grid_height_q) > MAX_GRID) eff_h = 7'(MAX_GRID);
		else eff_h = grid_height_q;
		if (tile_size_q == 9'd0) eff_ts = 9'd1;
		else if (tile_size_q > 9'd256) eff_ts = 9'd256;
		else eff_ts = tile_size_q;
	end

	assign ctr_col = POS_W'({1'b0, eff_w[6:1]});
	assign ctr_row = POS_W'({1'b0, eff_h[6:1]});

	function automatic logic in_grid(logic signed [POS_W-1:0] c, logic signed [POS_W-1:0] r,
		logic [6:0] w, logic [6:0] h);
		logic col_ok, row_ok;
		col_ok = !c[POS_W-1] && (POS_W'(c[POS_W-2:0]) < POS_W'(w));
		row_ok = !r[POS_W-1] && (POS_W'(r[POS_W-2:0]) < POS_W'(h));
		return col_ok && row_ok;
	endfunction

	// one spiral position, one leg turn or the sequence end per step
	always_comb begin
		col_n    = col_q;
		row_n    = row_q;
		ring_n   = ring_q;
		steps_n  = steps_q;
		leg_n    = leg_q;
		placed_n = placed_q;
		step_hit = 1'b0;
		step_end = 1'b0;
		if (leg_q == LEG_UP0) begin
			if (!placed_q || ring_q > RING_LIMIT) begin
				step_end = 1'b1;
			end else begin
				placed_n = 1'b0;
				row_n    = row_q - POS_W'(1);
				ring_n   = ring_q + RING_STEP;
				leg_n    = LEG_RIGHT;
				steps_n  = ring_q + 8'd1;
				step_hit = in_grid(col_q, row_q - POS_W'(1), eff_w, eff_h);
			end
		end else if (steps_q == 8'd0) begin
			// turn to the next leg, the last leg closes the ring
			if (leg_q >= LEG_UP) begin
				leg_n = LEG_UP0;
			end else begin
				leg_n   = leg_q + 3'd1;
				steps_n = ring_q;
			end
		end else begin
			steps_n = steps_q - 8'd1;
			case (leg_q)
				LEG_RIGHT: col_n = col_q + POS_W'(1);
				LEG_DOWN:  row_n = row_q + POS_W'(1);
				LEG_LEFT:  col_n = col_q - POS_W'(1);
				default:   row_n = row_q - POS_W'(1);
			endcase
			step_hit = in_grid(col_n, row_n, eff_w, eff_h);
		end
	end

	assign status.phase_idle = (phase_q == PH_IDLE);
	assign status.phase_walk = (phase_q == PH_WALK);
	assign status.hit        = step_hit;
	assign status.seq_end    = step_end;

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			ring_q   <= '0;
			steps_q  <= '0;
			leg_q    <= LEG_UP0;
			placed_q <= 1'b0;
			idx_q    <= '0;
			phase_q  <= PH_IDLE;
			done_q   <= 1'b0;
		end else if (cmd.start_center) begin
			col_q    <= ctr_col;
			row_q    <= ctr_row;
			ring_q   <= '0;
			steps_q  <= '0;
			leg_q    <= LEG_UP0;
			placed_q <= 1'b1;
			idx_q    <= 12'd1;
			phase_q  <= PH_WALK;
			done_q   <= 1'b0;
		end else if (cmd.step) begin
			col_q   <= col_n;
			row_q   <= row_n;
			ring_q  <= ring_n;
			steps_q <= steps_n;
			leg_q   <= leg_n;
			if (step_hit) begin
				placed_q <= 1'b1;
				idx_q    <= idx_q + 12'd1;
				done_q   <= 1'b0;
			end else begin
				placed_q <= placed_n;
			end
			if (step_end) begin
				phase_q <= PH_DONE;
				done_q  <= 1'b1;
			end
		end else if (cmd.set_done) begin
			done_q <= 1'b1;
		end
	end

	// index of the tile being produced
	always_ff @(posedge clk) begin
		if (cmd.start_center) cur_idx_q <= '0;
		else if (cmd.step && step_hit) cur_idx_q <= idx_q;
	end

	// pixel origin, position is inside the grid so nonnegative
	always_ff @(posedge clk) begin
		if (cmd.mult) begin
			prod_x_q <= PROD_W'(col_q[POS_W-2:0]) * PROD_W'(eff_ts);
			prod_y_q <= PROD_W'(row_q[POS_W-2:0]) * PROD_W'(eff_ts);
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			done_res   <= done_q;
			tile_index <= done_q ? 12'd0 : cur_idx_q;
			origin_x   <= done_q ? 14'd0 : prod_x_q[13:0];
			origin_y   <= done_q ? 14'd0 : prod_y_q[13:0];
		end
	end

endmodule

@@ hw/rtl/stog_ctrl.sv @@
// controller: request handshake, walk sequencing, output valid
module stog_ctrl
	import stog_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       restart,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_STEP = 4'b0010,
		ST_MULT = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   accept, out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (restart || status.phase_idle) begin
						cmd.start_center = 1'b1;
						state_n = ST_MULT;
					end else if (status.phase_walk) begin
						state_n = ST_STEP;
					end else begin
						cmd.set_done = 1'b1;
						state_n = ST_EMIT;
					end
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				if (status.seq_end) state_n = ST_EMIT;
				else if (status.hit) state_n = ST_MULT;
			end
			ST_MULT: begin
				cmd.mult = 1'b1;
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

@@ hw/rtl/spiral_tile_order_generator.sv @@
// top level: spiral tile order generator, one result beat per request beat
// sequence: accept in idle, a pass through the step state per spiral position visited or leg
// turn, a multiply and an output load; restart and center tile skip the steps, a done reply only loads
// flow: one request at a time; the next is taken once the result is loaded for output, and the
// load waits while a stalled result beat is still held
// reset: arst_n clears the walk to idle and sets the registers to 16, 16, 32
module spiral_tile_order_generator
	import stog_pkg::*;
#(
	parameter int MAX_GRID = MAX_GRID_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [11:0] tile_index, [25:12] origin_x, [39:26] origin_y
	output logic [0:0]  m_tuser    // [0] done_res
);

	ctrl_cmd_t   cmd;
	dp_status_t  status;
	logic [11:0] tile_index;
	logic [13:0] origin_x, origin_y;
	logic        done_res;

	// request sequencing
	stog_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.restart   (s_tdata[0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// walk state and arithmetic
	stog_dp #(.MAX_GRID(MAX_GRID)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.status     (status),
		.tile_index (tile_index),
		.origin_x   (origin_x),
		.origin_y   (origin_y),
		.done_res   (done_res)
	);

	// pack the result beat
	assign m_tdata    = {origin_y, origin_x, tile_index};
	assign m_tuser[0] = done_res;

endmodule

@@ hw/rtl/stog_checker.sv @@
// port checker for the spiral tile order generator and its bind
`include "assert_macros.svh"

module stog_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// a stalled result beat holds
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

	// a done beat carries no tile
	`ASSERT_ALWAYS(a_done_zero, !(m_tvalid && m_tuser[0]) || (m_tdata == 40'd0), "done beat with nonzero payload")

	// one request at a time
	`ASSERT_NEXT(a_one_req, s_tvalid && s_tready, !s_tready, "request taken while busy")

	// a request beat never yields a result in the next cycle
	`ASSERT_NEXT(a_min_latency, s_tvalid && s_tready && !(m_tvalid && !m_tready), !m_tvalid, "result appeared too early")

endmodule

bind spiral_tile_order_generator stog_checker u_stog_checker (.*);

@@ test/tb_spiral_tile_order_generator.sv @@
// self-checking testbench of the spiral tile order generator, stream ports and config writes
module tb_spiral_tile_order_generator;
	timeunit 1ns;
	timeprecision 1ps;
	import stog_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS   = 1100;
	localparam int SETTLE_CYCLES  = 8;

	// one result beat, fields as they leave the block
	typedef struct packed {
		logic        done;
		logic [13:0] oy;
		logic [13:0] ox;
		logic [11:0] idx;
	} tile_beat_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	// one row of the directed table
	typedef struct {
		row_kind_t   kind;
		logic [8:0]  w;
		logic [8:0]  h;
		logic [8:0]  ts;
		bit          rs;
		bit          known;
		tile_beat_t  want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_GRID_WIDTH;
	logic [8:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [0] restart
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // [11:0] tile_index, [25:12] origin_x, [39:26] origin_y
	logic [0:0]  m_tuser;        // [0] done_res

	spiral_tile_order_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #5 clk = ~clk;

	// register copies as written
	logic [6:0] shadow_w = GRID_WIDTH_RST;
	logic [6:0] shadow_h = GRID_HEIGHT_RST;
	logic [8:0] shadow_ts = TILE_SIZE_RST;

	// spiral walk state of the predictor
	int          sp_col = 0;
	int          sp_row = 0;
	int unsigned ring_len = 0;
	int unsigned steps_rem = 0;
	logic [2:0]  leg = LEG_UP0;
	bit          placed = 1'b0;
	logic [12:0] next_idx = '0;
	phase_t      sp_phase = PH_IDLE;

	tile_beat_t pending_tiles[$];
	bit         quiet = 1'b0;
	int         err_cnt = 0;
	int         req_cnt = 0;
	int         restart_cnt = 0;
	int         tile_cnt = 0;
	int         done_cnt = 0;
	int         write_cnt = 0;
	int         stall_cycles = 0;

	function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic bit in_grid(int unsigned gw, int unsigned gh);
		return sp_col >= 0 && sp_col < int'(gw) && sp_row >= 0 && sp_row < int'(gh);
	endfunction

	// advance the spiral by one request and form the tile it yields
	function automatic void spiral_advance(input bit rs, output tile_beat_t r);
		int unsigned gw, gh, ts;
		int          prod_x, prod_y;
		bit          hit;
		gw = clamp_to(shadow_w, 1, MAX_GRID_DEF);
		gh = clamp_to(shadow_h, 1, MAX_GRID_DEF);
		ts = clamp_to(shadow_ts, 1, 256);
		r = '0;
		hit = 1'b0;
		if (rs || sp_phase == PH_IDLE) begin
			sp_col = gw / 2;
			sp_row = gh / 2;
			ring_len = 0;
			leg = LEG_UP0;
			steps_rem = 0;
			next_idx = '0;
			placed = 1'b0;
			sp_phase = PH_WALK;
			hit = 1'b1;
		end else if (sp_phase != PH_WALK) begin
			r.done = 1'b1;
		end else begin
			// walk until a position lands in the grid or the ring comes up empty
			while (!hit && sp_phase == PH_WALK) begin
				if (leg == LEG_UP0) begin
					if (!placed || ring_len > RING_LIMIT) begin
						sp_phase = PH_DONE;
						r.done = 1'b1;
					end else begin
						placed = 1'b0;
						sp_row = sp_row - 1;
						ring_len = ring_len + RING_STEP;
						leg = LEG_RIGHT;
						steps_rem = ring_len - 1;
						hit = in_grid(gw, gh);
					end
				end else if (steps_rem == 0) begin
					leg = (leg >= LEG_UP) ? LEG_UP0 : leg + 3'd1;
					if (leg != LEG_UP0) steps_rem = ring_len;
				end else begin
					steps_rem = steps_rem - 1;
					case (leg)
						LEG_RIGHT: sp_col = sp_col + 1;
						LEG_DOWN:  sp_row = sp_row + 1;
						LEG_LEFT:  sp_col = sp_col - 1;
						default:   sp_row = sp_row - 1;
					endcase
					hit = in_grid(gw, gh);
				end
			end
		end
		if (hit) begin
			prod_x = sp_col * int'(ts);
			prod_y = sp_row * int'(ts);
			r.idx = next_idx[11:0];
			r.ox = prod_x[13:0];
			r.oy = prod_y[13:0];
			next_idx = next_idx + 13'd1;
			placed = 1'b1;
		end
	endfunction

	function automatic tile_beat_t beat(int unsigned idx, int unsigned ox, int unsigned oy,
		bit done);
		tile_beat_t b;
		b.idx = idx[11:0];
		b.ox = ox[13:0];
		b.oy = oy[13:0];
		b.done = done;
		return b;
	endfunction

	function automatic stim_row_t req_row(bit rs, bit known, tile_beat_t want);
		stim_row_t row;
		row.kind = ROW_REQ;
		row.w = '0;
		row.h = '0;
		row.ts = '0;
		row.rs = rs;
		row.known = known;
		row.want = want;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(int unsigned w, int unsigned h, int unsigned ts);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.w = w[8:0];
		row.h = h[8:0];
		row.ts = ts[8:0];
		row.rs = 1'b0;
		row.known = 1'b0;
		row.want = '0;
		return row;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
		$display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		err_cnt++;
	endtask

	// compare one output beat with the oldest pending tile
	task automatic check_beat();
		tile_beat_t got, want;
		got = {m_tuser[0], m_tdata[39:26], m_tdata[25:12], m_tdata[11:0]};
		if (pending_tiles.size() == 0) begin
			flag_mismatch("beat with no request pending, tile_index", got.idx, 0);
		end else begin
			want = pending_tiles.pop_front();
			if (got.idx !== want.idx) flag_mismatch("tile_index", got.idx, want.idx);
			if (got.ox !== want.ox) flag_mismatch("origin_x", got.ox, want.ox);
			if (got.oy !== want.oy) flag_mismatch("origin_y", got.oy, want.oy);
			if (got.done !== want.done) flag_mismatch("done_res", got.done, want.done);
			if (want.done) done_cnt++;
			else tile_cnt++;
		end
	endtask

	// output side with random back-pressure
	initial begin : sink
		int unsigned hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) check_beat();
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				hold = pick_gap();
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] no beat for %0d cycles, %0d tiles pending", $realtime,
				stall_cycles, pending_tiles.size());
			$display("[spiral_tile_order_generator] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic idle_for(int unsigned n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// one request beat; the predicted or the typed tile is queued on acceptance
	task automatic send_request(bit rs, bit known, tile_beat_t want);
		tile_beat_t pred;
		idle_for(pick_gap());
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, rs};
		do @(posedge clk); while (!s_tready);
		spiral_advance(rs, pred);
		pending_tiles.push_back(known ? want : pred);
		req_cnt++;
		if (rs) restart_cnt++;
	endtask

	// hold off the sender until every pending tile is out and the block is idle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_tiles.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(logic [8:0] w, logic [8:0] h, logic [8:0] ts);
		cfg_we <= 1'b1;
		cfg_index <= CFG_GRID_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= CFG_GRID_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_index <= CFG_TILE_SIZE;
		cfg_wdata <= ts;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_w = w[6:0];
		shadow_h = h[6:0];
		shadow_ts = ts;
		write_cnt += 3;
	endtask

	// stimulus: directed table, then random phases of settings and requests
	initial begin : stim
		stim_row_t   rows[$];
		int          rnd_start;
		int unsigned sel, n, area;
		logic [8:0]  w, h, ts;
		bit          first_rs, rs;

		// after reset, first ring, restart, tiny grid, saturation, strips and mid-walk changes
		rows.push_back(req_row(1'b0, 1'b1, beat(0, 256, 256, 1'b0)));
		rows.push_back(req_row(1'b0, 1'b1, beat(1, 256, 224, 1'b0)));
		rows.push_back(req_row(1'b0, 1'b0, '0));
		rows.push_back(req_row(1'b1, 1'b1, beat(0, 256, 256, 1'b0)));
		rows.push_back(cfg_row(1, 1, 256));
		rows.push_back(req_row(1'b0, 1'b0, '0));
		rows.push_back(req_row(1'b1, 1'b1, beat(0, 0, 0, 1'b0)));
		rows.push_back(req_row(1'b0, 1'b1, beat(0, 0, 0, 1'b1)));
		rows.push_back(req_row(1'b0, 1'b1, beat(0, 0, 0, 1'b1)));
		rows.push_back(cfg_row(0, 127, 0));
		rows.push_back(req_row(1'b1, 1'b1, beat(0, 0, 32, 1'b0)));
		rows.push_back(req_row(1'b0, 1'b1, beat(1, 0, 31, 1'b0)));
		rows.push_back(req_row(1'b0, 1'b0, '0));
		rows.push_back(req_row(1'b0, 1'b0, '0));
		rows.push_back(cfg_row(127, 127, 511));
		rows.push_back(req_row(1'b0, 1'b0, '0));
		rows.push_back(req_row(1'b1, 1'b1, beat(0, 8192, 8192, 1'b0)));
		rows.push_back(req_row(1'b0, 1'b0, '0));
		rows.push_back(req_row(1'b0, 1'b0, '0));
		rows.push_back(cfg_row(64, 1, 256));
		rows.push_back(req_row(1'b1, 1'b1, beat(0, 8192, 0, 1'b0)));
		rows.push_back(req_row(1'b0, 1'b0, '0));
		rows.push_back(cfg_row(1, 64, 1));
		rows.push_back(req_row(1'b1, 1'b1, beat(0, 0, 32, 1'b0)));
		rows.push_back(req_row(1'b0, 1'b0, '0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				drain();
				write_regs(rows[i].w, rows[i].h, rows[i].ts);
			end else begin
				send_request(rows[i].rs, rows[i].known, rows[i].want);
			end
		end

		// random phases: the first two walk full strips, then mostly small grids
		rnd_start = req_cnt;
		for (int ph = 0; req_cnt - rnd_start < RANDOM_ITEMS; ph++) begin
			drain();
			sel = $urandom_range(0, 19);
			ts = 9'($urandom_range(0, 511));
			if (ph < 2 || sel == 0) begin
				if (ph == 0 || (ph > 1 && $urandom_range(0, 1) == 1)) begin
					w = 9'($urandom_range(64, 127));
					h = 9'd1;
				end else begin
					w = 9'd1;
					h = 9'($urandom_range(64, 127));
				end
				n = 64 + $urandom_range(1, 4);
				first_rs = 1'b1;
			end else if (sel == 1) begin
				w = 9'($urandom_range(64, 127));
				h = 9'($urandom_range(64, 127));
				n = $urandom_range(40, 250);
				first_rs = 1'($urandom_range(0, 1));
			end else begin
				w = 9'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) :
					$urandom_range(0, 12));
				h = 9'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) :
					$urandom_range(0, 12));
				area = clamp_to(w[6:0], 1, MAX_GRID_DEF) * clamp_to(h[6:0], 1, MAX_GRID_DEF);
				n = clamp_to(area + $urandom_range(0, 4), 1, 300);
				if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
				first_rs = 1'($urandom_range(0, 1));
			end
			quiet = ($urandom_range(0, 4) == 0);
			write_regs(w, h, ts);
			for (int i = 0; i < int'(n); i++) begin
				rs = (i == 0) ? first_rs : ($urandom_range(0, 39) == 0);
				if ($urandom_range(0, 29) == 0) drain();
				send_request(rs, 1'b0, '0);
			end
		end

		quiet = 1'b0;
		drain();
		$display("run covered %0d requests (%0d restarts) over %0d register writes",
			req_cnt, restart_cnt, write_cnt);
		$display("checked %0d tiles and %0d exhausted replies, %0d mismatches",
			tile_cnt, done_cnt, err_cnt);
		if (err_cnt == 0) begin
			$display("[spiral_tile_order_generator] OK");
		end else begin
			$display("[spiral_tile_order_generator] ERROR");
		end
		$finish;
	end

endmodule
